FILE: rtl/rsas_pkg.sv
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rsas_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int POS_W           = 10;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                           cmd;
        logic signed [IN_VALUE_W-1:0]   value;
        logic                           first;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic               overflowed;
    } t_out;

    // outcome of one probe: match, direction, or a read of the upper bound needed
    typedef struct packed {
        logic hit;
        logic go_left;
        logic need_hi;
    } t_probe;

endpackage

FILE: rtl/rotated_sorted_array_search.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// A load is written in the accept cycle and busy stays low.
// A search sets up its range in the accept cycle; each probe then runs
// S_ISSUE (mid/low read), S_CMP and, when the right half is the sorted one,
// S_HI (upper-bound read); the strobe comes the cycle after the deciding state.
// Busy stays high through the probe loop over the shared two-read-port RAM.
// Reset clears element count and overflow flag; the store itself is not cleared.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search
    import rsas_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KB = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_CMP   = 4'b0100,
        S_HI    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_ovf, n_ovf;
    logic signed [CW:0]            r_lo, n_lo;
    logic signed [CW:0]            r_hi, n_hi;
    logic [AW-1:0]                 r_mid, n_mid;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic                          r_strobe, n_strobe;
    t_out                          r_result, n_result;

    logic signed [VALUE_WIDTH-1:0] in_key;
    logic [CW-1:0]                 load_base;
    logic [CW:0]                   mid_sum;
    logic [AW-1:0]                 mid_addr;
    logic [PW-1:0]                 mid_wide;
    logic                          wr_en;
    logic [AW-1:0]                 rd_addr_b;
    logic [VALUE_WIDTH-1:0]        rd_data_a, rd_data_b;
    t_probe                        probe;

    assign in_key    = VALUE_WIDTH'($signed(i_item.value[KB-1:0]));
    assign load_base = i_item.first ? '0 : r_count;
    assign mid_sum   = {1'b0, r_lo[CW-1:0]} + {1'b0, r_hi[CW-1:0]};
    assign mid_addr  = mid_sum[AW:1];
    assign mid_wide  = PW'(r_mid);
    assign rd_addr_b = (r_state == S_CMP) ? r_hi[AW-1:0] : r_lo[AW-1:0];
    assign wr_en     = (r_state == S_IDLE) && start && (i_item.cmd == CMD_LOAD)
                       && (load_base < CW'(DEPTH));

    rsas_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (load_base[AW-1:0]),
        .i_wr_data   (in_key),
        .i_rd_addr_a (mid_addr),
        .o_rd_data_a (rd_data_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (rd_data_b)
    );

    rsas_probe #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_probe (
        .i_mid_val (rd_data_a),
        .i_lo_val  (rd_data_b),
        .i_key     (r_key),
        .o_probe   (probe)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_key    = r_key;
        n_strobe = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.cmd == CMD_LOAD) begin
                        if (load_base < CW'(DEPTH)) begin
                            n_count = load_base + CW'(1);
                        end else begin
                            n_count = load_base;
                            n_ovf   = 1'b1;
                        end
                    end else begin
                        n_key   = in_key;
                        n_lo    = '0;
                        n_hi    = $signed({1'b0, r_count}) - (CW+1)'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (r_lo <= r_hi) begin
                    n_mid   = mid_addr;
                    n_state = S_CMP;
                end else begin
                    // search range exhausted
                    n_result.found      = 1'b0;
                    n_result.position   = '0;
                    n_result.overflowed = r_ovf;
                    n_strobe            = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_CMP: begin
                if (probe.hit) begin
                    n_result.found      = 1'b1;
                    n_result.position   = mid_wide[POS_W-1:0];
                    n_result.overflowed = r_ovf;
                    n_strobe            = 1'b1;
                    n_state             = S_IDLE;
                end else if (probe.need_hi) begin
                    n_state = S_HI;
                end else if (probe.go_left) begin
                    n_hi    = $signed({1'b0, CW'(r_mid)}) - (CW+1)'(1);
                    n_state = S_ISSUE;
                end else begin
                    n_lo    = $signed({1'b0, CW'(r_mid)}) + (CW+1)'(1);
                    n_state = S_ISSUE;
                end
            end
            S_HI: begin
                if ($signed(rd_data_b) >= r_key) begin
                    n_lo = $signed({1'b0, CW'(r_mid)}) + (CW+1)'(1);
                end else begin
                    n_hi = $signed({1'b0, CW'(r_mid)}) - (CW+1)'(1);
                end
                n_state = S_ISSUE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/rsas_ram.sv
// ----------------------------------------------------------------------------
// rsas_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    output logic [WIDTH-1:0] o_rd_data_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

FILE: rtl/rsas_probe.sv
// ----------------------------------------------------------------------------
// rsas_probe
// Probe decision: which half is sorted and whether the key lies inside it.
// ----------------------------------------------------------------------------
module rsas_probe
    import rsas_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0] i_mid_val,
    input  logic signed [VALUE_WIDTH-1:0] i_lo_val,
    input  logic signed [VALUE_WIDTH-1:0] i_key,
    output t_probe                        o_probe
);

    always_comb begin
        o_probe.hit     = (i_mid_val == i_key);
        o_probe.go_left = 1'b0;
        o_probe.need_hi = 1'b0;
        if (i_mid_val >= i_lo_val) begin
            // left half sorted
            o_probe.go_left = (i_mid_val > i_key) && (i_lo_val <= i_key);
        end else if (i_mid_val < i_key) begin
            // right half sorted, upper bound decides
            o_probe.need_hi = 1'b1;
        end else begin
            o_probe.go_left = 1'b1;
        end
    end

endmodule
